@@ rtl/amd_pkg.sv @@
package amd_pkg;

    // Window and pixel geometry
    localparam int N_PIX    = 9;
    localparam int PIX_W    = 24;
    localparam int CH_W     = 8;
    localparam int N_CH     = 3;
    localparam int MED_RANK = 4;
    localparam int CENTER   = 4;

    // Configuration registers
    localparam int THR_W  = 24;
    localparam int WGT_W  = 4;
    localparam int CFG_DW = 24;

    localparam logic [THR_W-1:0] THR_RST = 24'd209714;
    localparam logic [WGT_W-1:0] WGT_RST = 4'd5;

    typedef enum logic {
        CFG_THRESHOLD = 1'b0,
        CFG_WEIGHT    = 1'b1
    } t_cfg_idx;

    // Luma fraction bits
    localparam int FRAC_BITS_DEF = 16;

    // Pipeline map: lane stages, merge stages, channel stages (last one is the output)
    localparam int STG_LUMA = 0;
    localparam int STG_RANK = 1;
    localparam int STG_MRG  = 2;
    localparam int N_MRG    = 4;
    localparam int STG_CHAN = STG_MRG + N_MRG;
    localparam int N_DIV    = CH_W;
    localparam int N_CHAN   = N_DIV + 2;
    localparam int N_STG    = STG_CHAN + N_CHAN;

    // Rounded luma weight, weight given in units of 1e-4
    function automatic int amd_luma_coef(input int fb, input int w);
        longint v;
        v = (longint'(w) << fb) + 64'sd5000;
        return int'(v / 64'sd10000);
    endfunction

    function automatic int amd_luma_w(input int fb);
        return fb + 8;
    endfunction

    // Width of the threshold after rescaling to the luma fraction bits
    function automatic int amd_thr_w(input int fb);
        return (fb >= 16) ? (fb + 8) : THR_W;
    endfunction

    // Width of the denominator, seven times the scaled threshold
    function automatic int amd_den_w(input int fb);
        return amd_thr_w(fb) + 3;
    endfunction

endpackage

@@ rtl/adaptive_median_denoise_3x3_core.sv @@
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+--------------------------------------
// window   | in        | i_in_valid / o_in_ready      | i_pix_nw .. i_pix_se, RGB888 each
// result   | out       | o_out_valid / i_out_ready    | o_out_red, o_out_green, o_out_blue
// config   | in        | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// One window per clock is accepted while o_in_ready is high; each result passes through 16 register
// stages: luma, rank, four merge stages, one product stage, eight divider stages
// (one quotient bit each) and the output register.
// Reset is synchronous, active low; it clears the stage valid bits and loads the
// threshold and weight defaults. A stalled output holds its stage, and upstream
// stages keep filling empty slots, so input stays open until every stage is full.
module adaptive_median_denoise_3x3_core #(
    parameter int FRAC_BITS = amd_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  amd_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [amd_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [amd_pkg::PIX_W-1:0]     i_pix_nw,
    input  logic [amd_pkg::PIX_W-1:0]     i_pix_n,
    input  logic [amd_pkg::PIX_W-1:0]     i_pix_ne,
    input  logic [amd_pkg::PIX_W-1:0]     i_pix_w,
    input  logic [amd_pkg::PIX_W-1:0]     i_pix_c,
    input  logic [amd_pkg::PIX_W-1:0]     i_pix_e,
    input  logic [amd_pkg::PIX_W-1:0]     i_pix_sw,
    input  logic [amd_pkg::PIX_W-1:0]     i_pix_s,
    input  logic [amd_pkg::PIX_W-1:0]     i_pix_se,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [amd_pkg::CH_W-1:0]      o_out_red,
    output logic [amd_pkg::CH_W-1:0]      o_out_green,
    output logic [amd_pkg::CH_W-1:0]      o_out_blue
);
    import amd_pkg::*;

    localparam int LW  = amd_luma_w(FRAC_BITS);
    localparam int TW  = amd_thr_w(FRAC_BITS);
    localparam int DW  = amd_den_w(FRAC_BITS);
    localparam int SHL = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
    localparam int SHR = (FRAC_BITS >= 16) ? 0 : (16 - FRAC_BITS);

    logic [THR_W-1:0] r_thr;
    logic [WGT_W-1:0] r_wgt;
    logic [TW-1:0]    n_thr_s;
    logic [TW-1:0]    n_thr_nz;
    logic [DW-1:0]    r_den;

    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] w_rdy;

    logic [PIX_W-1:0] w_pix_in [N_PIX];
    logic [LW-1:0]    w_lum_early [N_PIX];
    logic [LW-1:0]    w_lum [N_PIX];
    logic [PIX_W-1:0] w_pix [N_PIX];
    logic [N_PIX-1:0] w_med;
    logic [N_PIX-1:0] w_mid;

    logic [DW-1:0]    w_num;
    logic [PIX_W-1:0] w_c_pix;
    logic [PIX_W-1:0] w_m_pix;
    logic [CH_W-1:0]  w_chan [N_CH];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RST;
            r_wgt <= WGT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                CFG_WEIGHT:    r_wgt <= i_cfg_data[WGT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Rescale the threshold to the luma fraction bits, force nonzero, times seven
    assign n_thr_s  = (TW'(r_thr) << SHL) >> SHR;
    assign n_thr_nz = (n_thr_s == '0) ? TW'(1) : n_thr_s;

    always_ff @(posedge i_clk) begin
        r_den <= (DW'(n_thr_nz) << 3) - DW'(n_thr_nz);
    end

    // Stage advance: a stage loads when it is empty or its successor moves
    always_comb begin
        w_rdy[N_STG-1] = !r_vld[N_STG-1] || i_out_ready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < N_STG; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[N_STG-1];

    // Window order sets the tie-break order of the sort
    assign w_pix_in[0] = i_pix_nw;
    assign w_pix_in[1] = i_pix_n;
    assign w_pix_in[2] = i_pix_ne;
    assign w_pix_in[3] = i_pix_w;
    assign w_pix_in[4] = i_pix_c;
    assign w_pix_in[5] = i_pix_e;
    assign w_pix_in[6] = i_pix_sw;
    assign w_pix_in[7] = i_pix_s;
    assign w_pix_in[8] = i_pix_se;

    for (genvar i = 0; i < N_PIX; i++) begin : g_lane
        amd_lane #(
            .FRAC_BITS (FRAC_BITS),
            .IDX       (i)
        ) u_lane (
            .i_clk       (i_clk),
            .i_en_luma   (w_rdy[STG_LUMA]),
            .i_en_rank   (w_rdy[STG_RANK]),
            .i_pix       (w_pix_in[i]),
            .i_lum_all   (w_lum_early),
            .o_lum_early (w_lum_early[i]),
            .o_lum       (w_lum[i]),
            .o_pix       (w_pix[i]),
            .o_med       (w_med[i]),
            .o_mid       (w_mid[i])
        );
    end

    amd_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (w_rdy[STG_MRG +: N_MRG]),
        .i_lum   (w_lum),
        .i_pix   (w_pix),
        .i_med   (w_med),
        .i_mid   (w_mid),
        .i_wgt   (r_wgt),
        .i_den   (r_den),
        .o_num   (w_num),
        .o_c_pix (w_c_pix),
        .o_m_pix (w_m_pix)
    );

    // Red, green, blue from the high byte down
    for (genvar c = 0; c < N_CH; c++) begin : g_chan
        localparam int SH = (N_CH - 1 - c) * CH_W;

        amd_blend_chan #(
            .FRAC_BITS (FRAC_BITS)
        ) u_chan (
            .i_clk  (i_clk),
            .i_en   (w_rdy[STG_CHAN +: N_CHAN]),
            .i_num  (w_num),
            .i_den  (r_den),
            .i_orig (w_c_pix[SH +: CH_W]),
            .i_med  (w_m_pix[SH +: CH_W]),
            .o_chan (w_chan[c])
        );
    end

    assign o_out_red   = w_chan[0];
    assign o_out_green = w_chan[1];
    assign o_out_blue  = w_chan[2];

    // An empty output stage must leave the input open
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[N_STG-1] |-> o_in_ready)
        else $error("input blocked with empty output stage");

    // A transfer lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[STG_LUMA])
        else $error("accepted window lost");

    // Ranks form a permutation: one median, seven middle entries
    a_one_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STG_RANK] |-> ($onehot(w_med) && ($countones(w_mid) == 7)))
        else $error("rank lanes disagree");

    // Clamped numerator never exceeds the denominator
    a_num_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STG_CHAN-1] |-> (w_num <= r_den))
        else $error("blend numerator above denominator");

endmodule

@@ rtl/amd_lane.sv @@
module amd_lane #(
    parameter int FRAC_BITS = amd_pkg::FRAC_BITS_DEF,
    parameter int IDX       = 0
) (
    input  logic                                       i_clk,
    input  logic                                       i_en_luma,
    input  logic                                       i_en_rank,
    input  logic [amd_pkg::PIX_W-1:0]                  i_pix,
    input  logic [amd_pkg::amd_luma_w(FRAC_BITS)-1:0]  i_lum_all [amd_pkg::N_PIX],
    output logic [amd_pkg::amd_luma_w(FRAC_BITS)-1:0]  o_lum_early,
    output logic [amd_pkg::amd_luma_w(FRAC_BITS)-1:0]  o_lum,
    output logic [amd_pkg::PIX_W-1:0]                  o_pix,
    output logic                                       o_med,
    output logic                                       o_mid
);
    import amd_pkg::*;

    localparam int LW = amd_luma_w(FRAC_BITS);
    localparam logic [LW-1:0] CR = LW'(amd_luma_coef(FRAC_BITS, 2126));
    localparam logic [LW-1:0] CG = LW'(amd_luma_coef(FRAC_BITS, 7152));
    localparam logic [LW-1:0] CB = LW'(amd_luma_coef(FRAC_BITS, 722));
    localparam logic [3:0] RANK_MED = 4'(MED_RANK);
    localparam logic [3:0] RANK_MAX = 4'(N_PIX - 1);

    logic [LW-1:0]    r_lum1;
    logic [PIX_W-1:0] r_pix1;
    logic [LW-1:0]    n_lum;
    logic [3:0]       n_cnt;

    // Luma of this pixel
    assign n_lum = CR * LW'(i_pix[23:16]) + CG * LW'(i_pix[15:8]) + CB * LW'(i_pix[7:0]);

    always_ff @(posedge i_clk) begin
        if (i_en_luma) begin
            r_lum1 <= n_lum;
            r_pix1 <= i_pix;
        end
    end

    assign o_lum_early = r_lum1;

    // Stable rank: count lanes that sort ahead, earlier lanes win ties
    always_comb begin
        n_cnt = '0;
        for (int j = 0; j < N_PIX; j++) begin
            if (j < IDX) begin
                if (i_lum_all[j] <= r_lum1) n_cnt = n_cnt + 4'd1;
            end else if (j > IDX) begin
                if (i_lum_all[j] < r_lum1) n_cnt = n_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_rank) begin
            o_lum <= r_lum1;
            o_pix <= r_pix1;
            o_med <= (n_cnt == RANK_MED);
            o_mid <= (n_cnt != 4'd0) && (n_cnt != RANK_MAX);
        end
    end

endmodule

@@ rtl/amd_merge.sv @@
module amd_merge #(
    parameter int FRAC_BITS = amd_pkg::FRAC_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic [amd_pkg::N_MRG-1:0]                  i_en,
    input  logic [amd_pkg::amd_luma_w(FRAC_BITS)-1:0]  i_lum [amd_pkg::N_PIX],
    input  logic [amd_pkg::PIX_W-1:0]                  i_pix [amd_pkg::N_PIX],
    input  logic [amd_pkg::N_PIX-1:0]                  i_med,
    input  logic [amd_pkg::N_PIX-1:0]                  i_mid,
    input  logic [amd_pkg::WGT_W-1:0]                  i_wgt,
    input  logic [amd_pkg::amd_den_w(FRAC_BITS)-1:0]   i_den,
    output logic [amd_pkg::amd_den_w(FRAC_BITS)-1:0]   o_num,
    output logic [amd_pkg::PIX_W-1:0]                  o_c_pix,
    output logic [amd_pkg::PIX_W-1:0]                  o_m_pix
);
    import amd_pkg::*;

    localparam int LW = amd_luma_w(FRAC_BITS);
    localparam int SW = LW + 3;
    localparam int NW = SW + WGT_W;
    localparam int DW = amd_den_w(FRAC_BITS);
    localparam int EW = (NW > DW) ? NW : DW;

    logic [LW-1:0]    n_lm;
    logic [PIX_W-1:0] n_mpix;
    logic [SW-1:0]    n_sum;
    logic [LW-1:0]    r_lm_a, r_lc_a;
    logic [SW-1:0]    r_sum_a;
    logic [PIX_W-1:0] r_c_a, r_m_a, r_c_b, r_m_b, r_c_c, r_m_c;
    logic [LW-1:0]    n_d1;
    logic [SW-1:0]    n_lm7;
    logic [SW-1:0]    r_pos_b, r_nd_b, r_pos_c;
    logic [NW-1:0]    r_neg_c;
    logic [EW-1:0]    n_pe, n_ne, n_diff;

    // Select the median pixel and sum the middle seven lumas
    always_comb begin
        n_lm   = '0;
        n_mpix = '0;
        n_sum  = '0;
        for (int i = 0; i < N_PIX; i++) begin
            if (i_med[i]) begin
                n_lm   = n_lm | i_lum[i];
                n_mpix = n_mpix | i_pix[i];
            end
            if (i_mid[i]) n_sum = n_sum + SW'(i_lum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lm_a  <= n_lm;
            r_lc_a  <= i_lum[CENTER];
            r_sum_a <= n_sum;
            r_c_a   <= i_pix[CENTER];
            r_m_a   <= n_mpix;
        end
    end

    // Both distances, scaled by seven so the mean stays exact
    assign n_d1  = (r_lm_a >= r_lc_a) ? (r_lm_a - r_lc_a) : (r_lc_a - r_lm_a);
    assign n_lm7 = (SW'(r_lm_a) << 3) - SW'(r_lm_a);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_pos_b <= (SW'(n_d1) << 3) - SW'(n_d1);
            r_nd_b  <= (n_lm7 >= r_sum_a) ? (n_lm7 - r_sum_a) : (r_sum_a - n_lm7);
            r_c_b   <= r_c_a;
            r_m_b   <= r_m_a;
        end
    end

    // Weight the noisiness term
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_neg_c <= NW'(i_wgt) * NW'(r_nd_b);
            r_pos_c <= r_pos_b;
            r_c_c   <= r_c_b;
            r_m_c   <= r_m_b;
        end
    end

    // Clamp the blend numerator to [0, den]
    assign n_pe   = EW'(r_pos_c);
    assign n_ne   = EW'(r_neg_c);
    assign n_diff = (n_pe > n_ne) ? (n_pe - n_ne) : '0;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            o_num   <= (n_diff > EW'(i_den)) ? i_den : DW'(n_diff);
            o_c_pix <= r_c_c;
            o_m_pix <= r_m_c;
        end
    end

endmodule

@@ rtl/amd_blend_chan.sv @@
module amd_blend_chan #(
    parameter int FRAC_BITS = amd_pkg::FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic [amd_pkg::N_CHAN-1:0]                i_en,
    input  logic [amd_pkg::amd_den_w(FRAC_BITS)-1:0]  i_num,
    input  logic [amd_pkg::amd_den_w(FRAC_BITS)-1:0]  i_den,
    input  logic [amd_pkg::CH_W-1:0]                  i_orig,
    input  logic [amd_pkg::CH_W-1:0]                  i_med,
    output logic [amd_pkg::CH_W-1:0]                  o_chan
);
    import amd_pkg::*;

    localparam int DW = amd_den_w(FRAC_BITS);
    localparam int RW = DW + CH_W;

    logic [RW-1:0]   r_rem [N_DIV+1];
    logic [CH_W-1:0] r_q   [N_DIV+1];
    logic [CH_W-1:0] r_o   [N_DIV+1];
    logic            r_up  [N_DIV+1];
    logic            n_up;
    logic [CH_W-1:0] n_diff;
    logic [CH_W:0]   n_dn;
    logic [CH_W:0]   n_res;

    // Product of the blend numerator and the channel step
    assign n_up   = (i_med >= i_orig);
    assign n_diff = n_up ? (i_med - i_orig) : (i_orig - i_med);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= RW'(i_num) * RW'(n_diff);
            r_q[0]   <= '0;
            r_o[0]   <= i_orig;
            r_up[0]  <= n_up;
        end
    end

    // Restoring division by den, one quotient bit per stage, MSB first
    for (genvar s = 0; s < N_DIV; s++) begin : g_div
        localparam int K = N_DIV - 1 - s;
        logic [RW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = RW'(i_den) << K;
        assign w_ge = (r_rem[s] >= w_sh);

        always_ff @(posedge i_clk) begin
            if (i_en[s+1]) begin
                r_rem[s+1] <= w_ge ? (r_rem[s] - w_sh) : r_rem[s];
                r_q[s+1]   <= {r_q[s][CH_W-2:0], w_ge};
                r_o[s+1]   <= r_o[s];
                r_up[s+1]  <= r_up[s];
            end
        end
    end

    // Floor the blended value: round the step up when moving down
    assign n_dn  = {1'b0, r_q[N_DIV]} + {{CH_W{1'b0}}, (r_rem[N_DIV] != '0)};
    assign n_res = r_up[N_DIV] ? ({1'b0, r_o[N_DIV]} + {1'b0, r_q[N_DIV]})
                               : ({1'b0, r_o[N_DIV]} - n_dn);

    always_ff @(posedge i_clk) begin
        if (i_en[N_CHAN-1]) begin
            o_chan <= n_res[CH_W-1:0];
        end
    end

endmodule

@@ verif/tb_adaptive_median_denoise_3x3_core.sv @@
module tb_adaptive_median_denoise_3x3_core;

    import amd_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int DRAIN      = N_STG + 4;
    localparam int IDLE_PCT   = 38;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 120;
    localparam int QUIET_MAX  = 4000;

    // Rounded luma weights at the block's fraction bits
    localparam longint unsigned LUMA_R = ((64'd2126 << FRAC) + 64'd5000) / 64'd10000;
    localparam longint unsigned LUMA_G = ((64'd7152 << FRAC) + 64'd5000) / 64'd10000;
    localparam longint unsigned LUMA_B = ((64'd722 << FRAC) + 64'd5000) / 64'd10000;

    typedef logic [N_PIX-1:0][PIX_W-1:0] t_window;
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    t_cfg_idx         cfg_idx = CFG_THRESHOLD;
    logic [CFG_DW-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_window          drv_window = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;

    // Shadow copy of the configuration registers
    logic [THR_W-1:0] thr_cfg = THR_RST;
    logic [WGT_W-1:0] wgt_cfg = WGT_RST;

    t_window pending_windows[$];
    t_rgb    expected_rgb[$];

    logic no_gaps = 1'b0;
    int   windows_sent = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   cfg_settings = 1;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    adaptive_median_denoise_3x3_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_pix_nw    (drv_window[0]),
        .i_pix_n     (drv_window[1]),
        .i_pix_ne    (drv_window[2]),
        .i_pix_w     (drv_window[3]),
        .i_pix_c     (drv_window[4]),
        .i_pix_e     (drv_window[5]),
        .i_pix_sw    (drv_window[6]),
        .i_pix_s     (drv_window[7]),
        .i_pix_se    (drv_window[8]),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_red   (out_red),
        .o_out_green (out_green),
        .o_out_blue  (out_blue)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint unsigned pixel_luma(logic [PIX_W-1:0] p);
        return LUMA_R * p[23:16] + LUMA_G * p[15:8] + LUMA_B * p[7:0];
    endfunction

    // Stable sort by luma, median blend against the centre pixel
    function automatic t_rgb predict_rgb(t_window w, logic [THR_W-1:0] thr,
                                         logic [WGT_W-1:0] wgt);
        longint unsigned srt_l[N_PIX];
        logic [PIX_W-1:0] srt_p[N_PIX];
        longint unsigned l, lc, lm, sum7, pos7, neg7, thr_s, den, num, o, m;
        logic [PIX_W-1:0] med;
        int pos;
        t_rgb r;
        for (int k = 0; k < N_PIX; k++) begin
            l = pixel_luma(w[k]);
            pos = k;
            for (int i = k - 1; i >= 0; i--) begin
                if (srt_l[i] > l) pos = i;
            end
            for (int j = k; j > pos; j--) begin
                srt_l[j] = srt_l[j-1];
                srt_p[j] = srt_p[j-1];
            end
            srt_l[pos] = l;
            srt_p[pos] = w[k];
        end
        lc = pixel_luma(w[CENTER]);
        med = srt_p[MED_RANK];
        lm = srt_l[MED_RANK];
        sum7 = 0;
        for (int i = 1; i < 8; i++) sum7 += srt_l[i];
        pos7 = 7 * ((lm >= lc) ? lm - lc : lc - lm);
        neg7 = wgt * ((7 * lm >= sum7) ? 7 * lm - sum7 : sum7 - 7 * lm);
        thr_s = thr;
        if (FRAC >= 16) thr_s = thr_s << (FRAC - 16);
        else thr_s = thr_s >> (16 - FRAC);
        if (thr_s == 0) thr_s = 1;
        den = 7 * thr_s;
        num = (pos7 > neg7) ? pos7 - neg7 : 0;
        if (num > den) num = den;
        for (int c = 0; c < N_CH; c++) begin
            o = w[CENTER][c*8 +: 8];
            m = med[c*8 +: 8];
            if (m >= o) r[c*8 +: 8] = 8'(o + (num * (m - o)) / den);
            else r[c*8 +: 8] = 8'(o - (num * (o - m) + den - 1) / den);
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] near_pixel(logic [PIX_W-1:0] base, int spread);
        logic [PIX_W-1:0] p;
        int v;
        for (int c = 0; c < N_CH; c++) begin
            v = int'(base[c*8 +: 8]) + int'($urandom_range(2 * spread)) - spread;
            if (v < 0) v = 0;
            else if (v > 255) v = 255;
            p[c*8 +: 8] = v[7:0];
        end
        return p;
    endfunction

    function automatic t_window flat_window(logic [PIX_W-1:0] p);
        t_window w;
        for (int k = 0; k < N_PIX; k++) w[k] = p;
        return w;
    endfunction

    // Mostly smooth fields with impulse or slightly off centres, plus ties, edges and noise
    function automatic t_window make_window();
        t_window w;
        logic [PIX_W-1:0] a, b;
        int kind, split;
        kind = $urandom_range(99);
        a = 24'($urandom);
        b = 24'($urandom);
        split = $urandom_range(8);
        for (int k = 0; k < N_PIX; k++) begin
            if (kind < 20) w[k] = 24'($urandom);
            else if (kind < 75) w[k] = near_pixel(a, 3);
            else if (kind < 90) w[k] = ($urandom_range(2) == 0) ? a : b;
            else w[k] = near_pixel((k < split) ? a : b, 2);
        end
        if (kind >= 20 && kind < 50) begin
            if ($urandom_range(3) == 0) w[CENTER] = {3{($urandom_range(1) != 0) ? 8'hFF : 8'h00}};
            else w[CENTER] = 24'($urandom);
            if ($urandom_range(4) == 0) w[$urandom_range(8)] = 24'($urandom);
        end else if (kind >= 50 && kind < 75) begin
            w[CENTER] = near_pixel(a, 12);
        end
        return w;
    endfunction

    task automatic check_chan(string nm, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, nm, want, got);
            mismatches++;
        end
    endtask

    // Wait until every window is through and the pipeline has drained
    task automatic settle();
        while (pending_windows.size() != 0 || in_valid || expected_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic run_phase(logic [CFG_DW-1:0] thr_data, logic [CFG_DW-1:0] wgt_data,
                             int count, logic gapless);
        settle();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_THRESHOLD;
        cfg_data <= thr_data;
        @(posedge clk);
        cfg_idx  <= CFG_WEIGHT;
        cfg_data <= wgt_data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        no_gaps  <= gapless;
        thr_cfg = thr_data[THR_W-1:0];
        wgt_cfg = wgt_data[WGT_W-1:0];
        cfg_settings++;
        repeat (count) pending_windows.push_back(make_window());
    endtask

    // Driver: offer pending windows, predict on each transfer
    always @(posedge clk) begin
        logic offer;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_rgb.push_back(predict_rgb(drv_window, thr_cfg, wgt_cfg));
                windows_sent++;
            end
            if (!in_valid || in_ready) begin
                offer = (pending_windows.size() != 0) &&
                        (no_gaps || $urandom_range(99) >= IDLE_PCT);
                if (offer) drv_window <= pending_windows.pop_front();
                in_valid <= offer;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk) begin
        t_rgb want;
        logic nxt_ready;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_rgb.size() == 0) begin
                    $display("%0t: result with nothing outstanding, expected none actual %0d %0d %0d",
                             $time, out_red, out_green, out_blue);
                    mismatches++;
                end else begin
                    want = expected_rgb.pop_front();
                    check_chan("red", want.red, out_red);
                    check_chan("green", want.green, out_green);
                    check_chan("blue", want.blue, out_blue);
                end
                if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
            end
            // Hold off for a long stretch once so the pipeline fills and stalls input
            if (hold_left != 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = no_gaps || $urandom_range(99) >= IDLE_PCT;
            end
            out_ready <= nxt_ready;
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_MAX) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        t_window w;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed windows under the reset defaults
        pending_windows.push_back(flat_window(24'h000000));
        pending_windows.push_back(flat_window(24'hFFFFFF));
        w = flat_window(24'h000000); w[CENTER] = 24'hFFFFFF; pending_windows.push_back(w);
        w = flat_window(24'hFFFFFF); w[CENTER] = 24'h000000; pending_windows.push_back(w);
        w = flat_window(24'h808080); w[CENTER] = 24'h818181; pending_windows.push_back(w);
        w = flat_window(24'h808080); w[CENTER] = 24'h848484; pending_windows.push_back(w);
        w = flat_window(24'h404040); w[CENTER] = 24'h404044; pending_windows.push_back(w);
        // partial blend with channels moving in opposite directions
        w = flat_window(24'h808080); w[CENTER] = 24'h8A7E80; pending_windows.push_back(w);
        w = flat_window(24'h00FF00); w[CENTER] = 24'hFF00FF; pending_windows.push_back(w);
        w = flat_window(24'hFF0000); w[CENTER] = 24'h0000FF; pending_windows.push_back(w);
        w = flat_window(24'h0000FF); w[CENTER] = 24'hFF0000; pending_windows.push_back(w);
        w = flat_window(24'h123456); w[CENTER] = 24'h123457; pending_windows.push_back(w);
        // checkerboard field, centre is the median
        for (int k = 0; k < N_PIX; k++) w[k] = (k % 2 != 0) ? 24'hFFFFFF : 24'h000000;
        w[CENTER] = 24'h808080;
        pending_windows.push_back(w);
        // noisy neighborhood weighs against the centre offset without cancelling it, blend stays partial
        for (int k = 0; k < N_PIX; k++)
            w[k] = (k < 3) ? 24'h000000 : (k > 5) ? 24'hFFFFFF : 24'h808080;
        w[CENTER] = 24'h848484;
        pending_windows.push_back(w);
        // descending ramp exercises the full sort
        for (int k = 0; k < N_PIX; k++) w[k] = 24'hFFFFFF - 24'(k) * 24'h1C1C1C;
        pending_windows.push_back(w);
        // repeated pixels, ties keep window order
        for (int k = 0; k < N_PIX; k++)
            w[k] = (k % 3 == 0) ? 24'h102030 : (k % 3 == 1) ? 24'h302010 : 24'hFFFFFF;
        pending_windows.push_back(w);
        // lone impulses away from the centre
        w = flat_window(24'h000000); w[0] = 24'hFFFFFF; pending_windows.push_back(w);
        w = flat_window(24'h000000); w[8] = 24'hFFFFFF; pending_windows.push_back(w);
        repeat (4) begin
            for (int k = 0; k < N_PIX; k++) w[k] = 24'($urandom);
            pending_windows.push_back(w);
        end

        // Random phases over several register settings
        run_phase(24'($urandom_range(400000, 20000)), 24'($urandom_range(15)), 200, 1'b0);
        run_phase(24'd1, 24'd0, 60, 1'b0);
        run_phase(24'hFFFFFF, 24'd15, 60, 1'b0);
        run_phase(24'd0, 24'd3, 50, 1'b0);
        run_phase(THR_RST, 24'(WGT_RST), 120, 1'b1);
        run_phase(24'($urandom), 24'($urandom), 60, 1'b0);

        settle();
        $display("covered %0d windows over %0d register settings, %0d results compared,",
                 windows_sent, cfg_settings, results_seen);
        $display("including a gapless stretch and a %0d-cycle output hold-off", HOLD_LEN);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ adaptive_median_denoise_3x3_core.f @@
rtl/amd_pkg.sv
rtl/amd_lane.sv
rtl/amd_merge.sv
rtl/amd_blend_chan.sv
rtl/adaptive_median_denoise_3x3_core.sv
verif/tb_adaptive_median_denoise_3x3_core.sv
